[design/bvm_pkg.sv]
// Shared types and opcode constants for the bytecode register VM execute block.
// No dependencies; every other design file refers to this package by scoped names.

package bvm_pkg;

	localparam int DATA_W = 64;
	localparam int FUNC_W = 3;
	localparam int BYTE_W = 8;
	localparam int OUT_PC_W = 12;

	localparam logic [FUNC_W-1:0] FUNC_LI    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_JMP   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_JGE   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_RET   = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_START = 3'd5;

	// Number of entries in the byte-indexed constant tables.
	localparam int BYTE_CODES = 256;

	// Register file write control produced by the execute logic.
	typedef struct packed {
		logic wen;   // write one register
		logic clr;   // clear every other register (start)
		logic done;  // run ends with this transaction
	} exec_ctl_t;

endpackage

[design/bvm_offset.sv]
// Branch offset decode: turns the jump offset bytes into (offset + 4) mod PROG_BYTES.
// Uses constant tables built at elaboration; depends on bvm_pkg.

module bvm_offset #(
	parameter int PROG_BYTES = 4096,
	parameter int PC_W = 12
) (
	input  logic [bvm_pkg::FUNC_W-1:0] func,
	input  logic [bvm_pkg::BYTE_W-1:0] field_b,
	input  logic [bvm_pkg::BYTE_W-1:0] field_c,
	output logic [PC_W-1:0]            off
);

	localparam logic [PC_W:0]   P_EXT = (PC_W+1)'(PROG_BYTES);
	localparam logic [PC_W-1:0] STEP  = PC_W'(4 % PROG_BYTES);

	logic [PC_W-1:0] hi_tab  [bvm_pkg::BYTE_CODES];
	logic [PC_W-1:0] lo_tab  [bvm_pkg::BYTE_CODES];
	logic [PC_W-1:0] jge_tab [bvm_pkg::BYTE_CODES];
	logic [PC_W:0]   jmp_sum;
	logic [PC_W-1:0] jmp_off;

	// High byte carries the sign and the +4 of the next instruction address.
	for (genvar i = 0; i < bvm_pkg::BYTE_CODES; i++) begin : g_tab
		localparam int SV   = (i >= 128) ? i - 256 : i;
		localparam int HV   = ((SV * 256 + 4) % PROG_BYTES + PROG_BYTES) % PROG_BYTES;
		localparam int LV   = i % PROG_BYTES;
		localparam int JV   = ((SV + 4) % PROG_BYTES + PROG_BYTES) % PROG_BYTES;
		assign hi_tab[i]  = PC_W'(HV);
		assign lo_tab[i]  = PC_W'(LV);
		assign jge_tab[i] = PC_W'(JV);
	end

	always_comb begin
		jmp_sum = {1'b0, hi_tab[field_b]} + {1'b0, lo_tab[field_c]};
		if (jmp_sum >= P_EXT) begin
			jmp_sum = jmp_sum - P_EXT;
		end
		jmp_off = jmp_sum[PC_W-1:0];
	end

	always_comb begin
		priority if (func == bvm_pkg::FUNC_JMP) begin
			off = jmp_off;
		end else if (func == bvm_pkg::FUNC_JGE) begin
			off = jge_tab[field_c];
		end else begin
			off = STEP;
		end
	end

endmodule

[design/bvm_regfile.sv]
// Register file: NUM_REGS x 64-bit memory with two registered read ports, one write port,
// per-entry valid bits for the start clear, and bypass of the write in flight. Uses bvm_pkg.

module bvm_regfile #(
	parameter int NUM_REGS = 256,
	parameter int REG_W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [bvm_pkg::BYTE_W-1:0]   rd_addr0,
	input  logic [bvm_pkg::BYTE_W-1:0]   rd_addr1,
	input  bvm_pkg::exec_ctl_t           wr_ctl,
	input  logic [bvm_pkg::BYTE_W-1:0]   wr_addr,
	input  logic [bvm_pkg::DATA_W-1:0]   wr_data,
	output logic [bvm_pkg::DATA_W-1:0]   rd_data0,
	output logic [bvm_pkg::DATA_W-1:0]   rd_data1
);

	localparam logic [1:0] SRC_MEM  = 2'd0;
	localparam logic [1:0] SRC_FWD  = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;

	logic [REG_W-1:0]           idx_tab [bvm_pkg::BYTE_CODES];
	logic [bvm_pkg::DATA_W-1:0] mem [NUM_REGS];
	logic [NUM_REGS-1:0]        valid_q;
	logic [NUM_REGS-1:0]        valid_nxt;
	logic [bvm_pkg::DATA_W-1:0] rd0_q;
	logic [bvm_pkg::DATA_W-1:0] rd1_q;
	logic [bvm_pkg::DATA_W-1:0] fwd_q;
	logic [1:0]                 sel0_q;
	logic [1:0]                 sel1_q;
	logic [1:0]                 sel0;
	logic [1:0]                 sel1;
	logic [REG_W-1:0]           idx0;
	logic [REG_W-1:0]           idx1;
	logic [REG_W-1:0]           widx;

	// Register index reduced modulo NUM_REGS.
	for (genvar i = 0; i < bvm_pkg::BYTE_CODES; i++) begin : g_idx
		localparam int IV = i % NUM_REGS;
		assign idx_tab[i] = REG_W'(IV);
	end

	assign idx0 = idx_tab[rd_addr0];
	assign idx1 = idx_tab[rd_addr1];
	assign widx = idx_tab[wr_addr];

	always_ff @(posedge clk) begin
		if (wr_ctl.wen) begin
			mem[widx] <= wr_data;
		end
		if (rd_en) begin
			rd0_q <= mem[idx0];
			rd1_q <= mem[idx1];
			fwd_q <= wr_data;
		end
	end

	always_comb begin
		valid_nxt = valid_q;
		if (wr_ctl.wen) begin
			if (wr_ctl.clr) begin
				valid_nxt = '0;
			end
			valid_nxt[widx] = 1'b1;
		end
	end

	// Pick the operand source at read time; the memory returns old data on a same-edge write.
	always_comb begin
		priority if (wr_ctl.wen && (widx == idx0)) begin
			sel0 = SRC_FWD;
		end else if ((wr_ctl.wen && wr_ctl.clr) || !valid_q[idx0]) begin
			sel0 = SRC_ZERO;
		end else begin
			sel0 = SRC_MEM;
		end
		priority if (wr_ctl.wen && (widx == idx1)) begin
			sel1 = SRC_FWD;
		end else if ((wr_ctl.wen && wr_ctl.clr) || !valid_q[idx1]) begin
			sel1 = SRC_ZERO;
		end else begin
			sel1 = SRC_MEM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			sel0_q  <= SRC_ZERO;
			sel1_q  <= SRC_ZERO;
		end else begin
			valid_q <= valid_nxt;
			if (rd_en) begin
				sel0_q <= sel0;
				sel1_q <= sel1;
			end
		end
	end

	always_comb begin
		unique case (sel0_q)
			SRC_MEM:  rd_data0 = rd0_q;
			SRC_FWD:  rd_data0 = fwd_q;
			default:  rd_data0 = '0;
		endcase
		unique case (sel1_q)
			SRC_MEM:  rd_data1 = rd1_q;
			SRC_FWD:  rd_data1 = fwd_q;
			default:  rd_data1 = '0;
		endcase
	end

endmodule

[design/bvm_exec.sv]
// Execute logic for one instruction: register write, next program counter and run result.
// Purely combinational; depends on bvm_pkg.

module bvm_exec #(
	parameter int PROG_BYTES = 4096,
	parameter int PC_W = 12
) (
	input  logic [bvm_pkg::FUNC_W-1:0] func,
	input  logic [bvm_pkg::BYTE_W-1:0] field_a,
	input  logic [bvm_pkg::BYTE_W-1:0] field_b,
	input  logic [bvm_pkg::BYTE_W-1:0] field_c,
	input  logic [bvm_pkg::DATA_W-1:0] argument,
	input  logic [bvm_pkg::DATA_W-1:0] opnd0,
	input  logic [bvm_pkg::DATA_W-1:0] opnd1,
	input  logic [PC_W-1:0]            pc,
	input  logic [PC_W-1:0]            off,
	output bvm_pkg::exec_ctl_t         ctl,
	output logic [bvm_pkg::BYTE_W-1:0] wr_addr,
	output logic [bvm_pkg::DATA_W-1:0] wr_data,
	output logic [PC_W-1:0]            pc_nxt,
	output logic [bvm_pkg::DATA_W-1:0] value
);

	localparam logic [PC_W:0]   P_EXT = (PC_W+1)'(PROG_BYTES);
	localparam logic [PC_W-1:0] STEP  = PC_W'(4 % PROG_BYTES);

	logic [PC_W-1:0] step_off;
	logic [PC_W:0]   pc_sum;
	logic [PC_W-1:0] pc_adv;

	// Not-taken compare falls through to the next instruction.
	assign step_off = (func == bvm_pkg::FUNC_JGE && opnd0 < opnd1) ? STEP : off;

	always_comb begin
		pc_sum = {1'b0, pc} + {1'b0, step_off};
		if (pc_sum >= P_EXT) begin
			pc_sum = pc_sum - P_EXT;
		end
		pc_adv = pc_sum[PC_W-1:0];
	end

	always_comb begin
		ctl     = '0;
		wr_addr = field_a;
		wr_data = opnd0 + opnd1;
		pc_nxt  = pc_adv;
		value   = '0;
		unique case (func)
			bvm_pkg::FUNC_LI: begin
				ctl.wen = 1'b1;
				wr_data = {{(bvm_pkg::DATA_W-16){field_b[7]}}, field_b, field_c};
			end
			bvm_pkg::FUNC_ADD: begin
				ctl.wen = 1'b1;
			end
			bvm_pkg::FUNC_JMP,
			bvm_pkg::FUNC_JGE: begin
				ctl.wen = 1'b0;
			end
			bvm_pkg::FUNC_RET: begin
				ctl.done = 1'b1;
				value    = opnd1;
				pc_nxt   = '0;
			end
			bvm_pkg::FUNC_START: begin
				ctl.wen = 1'b1;
				ctl.clr = 1'b1;
				wr_addr = '0;
				wr_data = argument;
				pc_nxt  = '0;
			end
			default: begin
				ctl.done = 1'b1;
				pc_nxt   = '0;
			end
		endcase
	end

endmodule

[design/bytecode_register_vm_execute_top.sv]
// An accepted transaction is registered in stage s1 and moves into the output register when s1
// advances, which a stalled result holds off. Throughput: one instruction per cycle unless the
// result is stalled; operands come from the register file's two registered read ports, bypassed
// from the instruction executing in the same cycle. Reset: arst_n clears the program counter, all
// register valid bits (registers read 0) and both valid flags; a transaction is taken once reset ends.
// Depends on bvm_pkg, bvm_offset, bvm_regfile, bvm_exec.

module bytecode_register_vm_execute_top #(
	parameter int NUM_REGS = 256,
	parameter int PROG_BYTES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bvm_pkg::FUNC_W-1:0]          func,
	input  logic [bvm_pkg::BYTE_W-1:0]          field_a,
	input  logic [bvm_pkg::BYTE_W-1:0]          field_b,
	input  logic [bvm_pkg::BYTE_W-1:0]          field_c,
	input  logic [bvm_pkg::DATA_W-1:0]          argument,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bvm_pkg::OUT_PC_W-1:0]        next_pc,
	output logic                                done_res,
	output logic [bvm_pkg::DATA_W-1:0]          ret_value
);

	localparam int REG_W = $clog2(NUM_REGS);
	localparam int PC_W  = $clog2(PROG_BYTES);

	logic                         accept;
	logic                         advance;
	logic                         valid_s1;
	logic [bvm_pkg::FUNC_W-1:0]   func_s1;
	logic [bvm_pkg::BYTE_W-1:0]   a_s1;
	logic [bvm_pkg::BYTE_W-1:0]   b_s1;
	logic [bvm_pkg::BYTE_W-1:0]   c_s1;
	logic [bvm_pkg::DATA_W-1:0]   arg_s1;
	logic [PC_W-1:0]              off_s1;
	logic [PC_W-1:0]              off_in;
	logic [PC_W-1:0]              pc_q;
	logic [PC_W-1:0]              pc_nxt;
	logic [bvm_pkg::BYTE_W-1:0]   rd_addr0;
	logic [bvm_pkg::BYTE_W-1:0]   rd_addr1;
	logic [bvm_pkg::DATA_W-1:0]   opnd0;
	logic [bvm_pkg::DATA_W-1:0]   opnd1;
	bvm_pkg::exec_ctl_t           ctl;
	bvm_pkg::exec_ctl_t           wr_ctl;
	logic [bvm_pkg::BYTE_W-1:0]   wr_addr;
	logic [bvm_pkg::DATA_W-1:0]   wr_data;
	logic [bvm_pkg::DATA_W-1:0]   value;
	logic [PC_W+bvm_pkg::OUT_PC_W-1:0] pc_wide;
	logic                         out_valid_q;
	logic [bvm_pkg::OUT_PC_W-1:0] next_pc_q;
	logic                         done_q;
	logic [bvm_pkg::DATA_W-1:0]   ret_value_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Port 0 reads the first compare register or the first add source; port 1 the other.
	assign rd_addr0 = (func == bvm_pkg::FUNC_JGE) ? field_a : field_b;
	assign rd_addr1 = (func == bvm_pkg::FUNC_ADD || func == bvm_pkg::FUNC_RET) ?
		field_c : field_b;

	bvm_offset #(
		.PROG_BYTES (PROG_BYTES),
		.PC_W       (PC_W)
	) u_offset (
		.func    (func),
		.field_b (field_b),
		.field_c (field_c),
		.off     (off_in)
	);

	// Gate the state update with the stage moving on.
	always_comb begin
		wr_ctl     = ctl;
		wr_ctl.wen = ctl.wen && advance;
	end

	bvm_regfile #(
		.NUM_REGS (NUM_REGS),
		.REG_W    (REG_W)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.wr_ctl   (wr_ctl),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_data0 (opnd0),
		.rd_data1 (opnd1)
	);

	bvm_exec #(
		.PROG_BYTES (PROG_BYTES),
		.PC_W       (PC_W)
	) u_exec (
		.func     (func_s1),
		.field_a  (a_s1),
		.field_b  (b_s1),
		.field_c  (c_s1),
		.argument (arg_s1),
		.opnd0    (opnd0),
		.opnd1    (opnd1),
		.pc       (pc_q),
		.off      (off_s1),
		.ctl      (ctl),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.pc_nxt   (pc_nxt),
		.value    (value)
	);

	assign pc_wide = {{bvm_pkg::OUT_PC_W{1'b0}}, pc_nxt};

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			a_s1    <= field_a;
			b_s1    <= field_b;
			c_s1    <= field_c;
			arg_s1  <= argument;
			off_s1  <= off_in;
		end
		if (advance) begin
			next_pc_q   <= pc_wide[bvm_pkg::OUT_PC_W-1:0];
			done_q      <= ctl.done;
			ret_value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				pc_q        <= pc_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign next_pc   = next_pc_q;
	assign done_res  = done_q;
	assign ret_value = ret_value_q;

endmodule

[design/bvm_checker.sv]
// Port-level checks for the bytecode register VM execute block, bound to its top level.
// Sees only the top-level ports; depends on bvm_pkg.

module bvm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [bvm_pkg::OUT_PC_W-1:0] next_pc,
	input logic                         done_res,
	input logic [bvm_pkg::DATA_W-1:0]   ret_value
);

	// A finished run restarts fetch at address zero.
	a_done_pc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> next_pc == '0)
		else $error("done result with nonzero next_pc");

	// Only a finished run carries a value.
	a_value_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> ret_value == '0)
		else $error("ret_value nonzero on a result that is not done");

	// Input back-pressure comes only from a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without a stalled result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ret_value) && $stable(next_pc))
		else $error("stalled result changed");

endmodule

bind bytecode_register_vm_execute_top bvm_checker u_bvm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.next_pc   (next_pc),
	.done_res  (done_res),
	.ret_value (ret_value)
);

[tb/bvm_execute_checker.sv]
// Checker for bytecode_register_vm_execute_top: watches both channels, predicts each result.
// Depends on bvm_pkg; reports mismatches and hands the failure and backlog counts upward.
`timescale 1ns / 100ps

module bvm_execute_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [bvm_pkg::FUNC_W-1:0]   func,
	input  logic [bvm_pkg::BYTE_W-1:0]   field_a,
	input  logic [bvm_pkg::BYTE_W-1:0]   field_b,
	input  logic [bvm_pkg::BYTE_W-1:0]   field_c,
	input  logic [bvm_pkg::DATA_W-1:0]   argument,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [bvm_pkg::OUT_PC_W-1:0] next_pc,
	input  logic                         done_res,
	input  logic [bvm_pkg::DATA_W-1:0]   ret_value,
	output int                           fail_count,
	output int                           pending
);

	typedef logic [bvm_pkg::DATA_W-1:0] word_t;

	typedef struct packed {
		logic [bvm_pkg::OUT_PC_W-1:0] pc;
		logic                         done;
		logic [bvm_pkg::DATA_W-1:0]   value;
	} vm_result_t;

	logic [bvm_pkg::DATA_W-1:0]   vm_regs [0:bvm_pkg::BYTE_CODES-1];
	logic [bvm_pkg::OUT_PC_W-1:0] vm_pc;
	vm_result_t                   expected_results [$];
	vm_result_t                   want;
	vm_result_t                   got_pred;
	int                           printed;
	int                           idx;

	initial begin
		fail_count = 0;
		pending = 0;
		printed = 0;
	end

	task automatic report_mismatch(input string what, input word_t got, input word_t exp_val);
		if (printed < 60)
			$display("%0t ns: %s: got %h, expected %h", $time, what, got, exp_val);
		printed++;
		fail_count++;
	endtask

	// Execute one instruction on the shadow machine and form its result.
	task automatic execute_instr(input logic [bvm_pkg::FUNC_W-1:0] op,
			input logic [bvm_pkg::BYTE_W-1:0] a, input logic [bvm_pkg::BYTE_W-1:0] b,
			input logic [bvm_pkg::BYTE_W-1:0] c, input logic [bvm_pkg::DATA_W-1:0] arg,
			output vm_result_t res);
		logic [15:0] imm;
		imm = {b, c};
		res.done = 1'b0;
		res.value = '0;
		case (op)
			bvm_pkg::FUNC_LI: begin
				vm_regs[a] = {{48{imm[15]}}, imm};
				vm_pc = vm_pc + 12'd4;
			end
			bvm_pkg::FUNC_ADD: begin
				vm_regs[a] = vm_regs[b] + vm_regs[c];
				vm_pc = vm_pc + 12'd4;
			end
			// counter is 12 bits wide, so the offset only matters modulo 4096
			bvm_pkg::FUNC_JMP: vm_pc = vm_pc + 12'd4 + imm[11:0];
			bvm_pkg::FUNC_JGE: begin
				if (vm_regs[a] >= vm_regs[b])
					vm_pc = vm_pc + 12'd4 + {{4{c[7]}}, c};
				else
					vm_pc = vm_pc + 12'd4;
			end
			bvm_pkg::FUNC_RET: begin
				res.done = 1'b1;
				res.value = vm_regs[c];
				vm_pc = '0;
			end
			bvm_pkg::FUNC_START: begin
				for (int r = 0; r < bvm_pkg::BYTE_CODES; r++)
					vm_regs[r] = '0;
				vm_regs[0] = arg;
				vm_pc = '0;
			end
			default: begin
				res.done = 1'b1;
				vm_pc = '0;
			end
		endcase
		res.pc = vm_pc;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (idx = 0; idx < bvm_pkg::BYTE_CODES; idx++)
				vm_regs[idx] = '0;
			vm_pc = '0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no transaction pending", word_t'(next_pc), '0);
				end else begin
					want = expected_results.pop_front();
					if (next_pc !== want.pc)
						report_mismatch("next_pc", word_t'(next_pc), word_t'(want.pc));
					if (done_res !== want.done)
						report_mismatch("done_res", word_t'(done_res), word_t'(want.done));
					if (ret_value !== want.value)
						report_mismatch("ret_value", ret_value, want.value);
				end
			end
			if (in_valid && !in_stall) begin
				execute_instr(func, field_a, field_b, field_c, argument, got_pred);
				expected_results.push_back(got_pred);
			end
			pending = expected_results.size();
		end
	end

endmodule

[tb/bytecode_register_vm_execute_top_tb.sv]
// Testbench top for bytecode_register_vm_execute_top: clock, reset, stimulus and verdict.
// Depends on bvm_pkg, the block itself and bvm_execute_checker, which checks every result.
`timescale 1ns / 100ps

module bytecode_register_vm_execute_top_tb;

	localparam logic [bvm_pkg::FUNC_W-1:0] FUNC_BAD6 = 3'd6;
	localparam logic [bvm_pkg::FUNC_W-1:0] FUNC_BAD7 = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 80;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [bvm_pkg::FUNC_W-1:0]   func = '0;
	logic [bvm_pkg::BYTE_W-1:0]   field_a = '0;
	logic [bvm_pkg::BYTE_W-1:0]   field_b = '0;
	logic [bvm_pkg::BYTE_W-1:0]   field_c = '0;
	logic [bvm_pkg::DATA_W-1:0]   argument = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [bvm_pkg::OUT_PC_W-1:0] next_pc;
	logic                         done_res;
	logic [bvm_pkg::DATA_W-1:0]   ret_value;

	int   fail_count;
	int   pending;
	int   cycles = 0;
	int   items_sent = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   hold_left = 0;
	bit   hold_req = 0;
	logic in_taken = 1'b0;

	bytecode_register_vm_execute_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .field_a(field_a), .field_b(field_b), .field_c(field_c),
		.argument(argument),
		.out_valid(out_valid), .out_stall(out_stall),
		.next_pc(next_pc), .done_res(done_res), .ret_value(ret_value)
	);

	bvm_execute_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .field_a(field_a), .field_b(field_b), .field_c(field_c),
		.argument(argument),
		.out_valid(out_valid), .out_stall(out_stall),
		.next_pc(next_pc), .done_res(done_res), .ret_value(ret_value),
		.fail_count(fail_count), .pending(pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: random stall, or a long hold-off when requested.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic logic [bvm_pkg::DATA_W-1:0] rand_word();
		case ($urandom_range(7))
			0: rand_word = '0;
			1: rand_word = '1;
			2: rand_word = {1'b1, 63'b0};
			3: rand_word = 64'($urandom_range(15));
			default: rand_word = {$urandom, $urandom};
		endcase
	endfunction

	// Mostly a few low registers so values interact; now and then any index or one of the top four.
	function automatic logic [bvm_pkg::BYTE_W-1:0] pick_reg();
		case ($urandom_range(9))
			0: pick_reg = 8'($urandom);
			1: pick_reg = 8'hFF - 8'($urandom_range(3));
			default: pick_reg = 8'($urandom_range(7));
		endcase
	endfunction

	// Call at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input logic [bvm_pkg::FUNC_W-1:0] op,
			input logic [bvm_pkg::BYTE_W-1:0] a, input logic [bvm_pkg::BYTE_W-1:0] b,
			input logic [bvm_pkg::BYTE_W-1:0] c, input logic [bvm_pkg::DATA_W-1:0] arg);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		field_a <= a;
		field_b <= b;
		field_c <= c;
		argument <= arg;
		do
			@(negedge clk);
		while (!in_taken);
		items_sent++;
	endtask

	// Drop valid and hold until every result is back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic run_program();
		int n;
		int pick;
		logic [15:0] imm;
		send_item(bvm_pkg::FUNC_START, 8'($urandom), 8'($urandom), 8'($urandom), rand_word());
		n = $urandom_range(2, 16);
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			imm = ($urandom_range(4) == 0) ? (($urandom_range(1) == 0) ? 16'h8000 : 16'h7FFF)
				: 16'($urandom);
			if (pick < 35)
				send_item(bvm_pkg::FUNC_LI, pick_reg(), imm[15:8], imm[7:0], rand_word());
			else if (pick < 65)
				send_item(bvm_pkg::FUNC_ADD, pick_reg(), pick_reg(), pick_reg(), rand_word());
			else if (pick < 85)
				send_item(bvm_pkg::FUNC_JGE, pick_reg(), pick_reg(), 8'($urandom),
					rand_word());
			else
				send_item(bvm_pkg::FUNC_JMP, 8'($urandom), imm[15:8], imm[7:0], rand_word());
		end
		if ($urandom_range(9) < 8)
			send_item(bvm_pkg::FUNC_RET, 8'($urandom), 8'($urandom), pick_reg(), rand_word());
		else
			send_item(($urandom_range(1) == 0) ? FUNC_BAD6 : FUNC_BAD7,
				8'($urandom), 8'($urandom), 8'($urandom), rand_word());
	endtask

	task automatic run_phase(input int target);
		while (items_sent < target) begin
			if ($urandom_range(9) == 0)
				send_item(3'($urandom_range(7)), 8'($urandom), 8'($urandom), 8'($urandom),
					rand_word());
			else
				run_program();
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, every opcode, wrap and after-end cases.
		send_item(bvm_pkg::FUNC_START, 8'h00, 8'h00, 8'h00, '1);
		send_item(bvm_pkg::FUNC_LI, 8'h01, 8'h00, 8'h01, '0);
		send_item(bvm_pkg::FUNC_ADD, 8'h02, 8'h00, 8'h01, '0);      // all ones + 1 wraps to 0
		send_item(bvm_pkg::FUNC_LI, 8'hFF, 8'h80, 8'h00, '0);
		send_item(bvm_pkg::FUNC_LI, 8'hFE, 8'h7F, 8'hFF, '0);
		send_item(bvm_pkg::FUNC_ADD, 8'hFF, 8'hFF, 8'hFE, '0);
		send_item(bvm_pkg::FUNC_JMP, 8'h00, 8'h80, 8'h00, '0);      // most negative jump, wraps
		send_item(bvm_pkg::FUNC_JMP, 8'hFF, 8'h7F, 8'hFF, '0);
		send_item(bvm_pkg::FUNC_JGE, 8'h00, 8'h01, 8'h7F, '0);      // taken, largest forward
		send_item(bvm_pkg::FUNC_JGE, 8'h01, 8'h00, 8'h80, '0);      // not taken
		send_item(bvm_pkg::FUNC_JGE, 8'h03, 8'h04, 8'h80, '0);      // equal, taken backward
		send_item(bvm_pkg::FUNC_JMP, 8'h00, 8'hFF, 8'hFC, '0);      // jump to self
		send_item(bvm_pkg::FUNC_RET, 8'h00, 8'h00, 8'hFF, '0);
		send_item(bvm_pkg::FUNC_LI, 8'h03, 8'h12, 8'h34, '0);       // runs on after the end
		send_item(bvm_pkg::FUNC_RET, 8'hFF, 8'hFF, 8'h03, '0);
		send_item(FUNC_BAD6, 8'hFF, 8'hFF, 8'hFF, '1);
		send_item(FUNC_BAD7, 8'h00, 8'h00, 8'h00, '0);
		send_item(bvm_pkg::FUNC_START, 8'hFF, 8'hFF, 8'hFF, '0);
		send_item(bvm_pkg::FUNC_RET, 8'h00, 8'h00, 8'h00, '0);
		send_item(bvm_pkg::FUNC_START, 8'h00, 8'h00, 8'h00, {$urandom, $urandom});
		send_item(bvm_pkg::FUNC_ADD, 8'h00, 8'h00, 8'h00, '0);
		send_item(bvm_pkg::FUNC_RET, 8'h00, 8'h00, 8'h00, '0);
		drain();

		// Long receiver hold-off while the sender keeps offering.
		hold_req = 1;
		run_phase(items_sent + 150);
		drain();

		idle_pct = 54;
		stall_pct = 0;
		run_phase(items_sent + 150);
		drain();

		idle_pct = 0;
		stall_pct = 54;
		hold_req = 1;
		run_phase(items_sent + 150);
		drain();

		idle_pct = 15;
		stall_pct = 15;
		run_phase(items_sent + 150);
		drain();

		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
